// File: rtl/i2cm_pkg.sv
// Shared types and constants for the I2C master byte engine.
`timescale 1ns / 1ps

package i2cm_pkg;

   // Register reset values
   localparam logic [15:0] UNIT_TICKS_RESET = 16'd16;
   localparam logic [7:0]  ACK_WAIT_RESET   = 8'd36;

   // Configuration register indexes
   localparam logic CSR_UNIT_TICKS = 1'b0;
   localparam logic CSR_ACK_WAIT   = 1'b1;

   // Default depth of the queue between front and back
   localparam int I2CM_QUEUE_DEPTH = 2;

   // Raw command codes on the request channel
   localparam logic [2:0] CODE_NONE  = 3'd0;
   localparam logic [2:0] CODE_TAKE  = 3'd1;
   localparam logic [2:0] CODE_START = 3'd2;
   localparam logic [2:0] CODE_STOP  = 3'd3;
   localparam logic [2:0] CODE_WRITE = 3'd4;
   localparam logic [2:0] CODE_READ  = 3'd5;

   // Classified command carried through the queue
   typedef enum logic [2:0] {
      KIND_NONE,
      KIND_TAKE,
      KIND_START,
      KIND_STOP,
      KIND_WRITE,
      KIND_READ,
      KIND_UNKNOWN
   } cmd_type;

   typedef struct packed {
      cmd_type    kind;
      logic [7:0] write_data;
      logic       send_ack;
      logic       sda_in;
   } item_type;

endpackage

// File: rtl/i2cm_if.sv
// Request and response channel interfaces of the I2C master byte engine.
`timescale 1ns / 1ps

interface i2cm_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] command;
   logic [7:0] write_data;
   logic       send_ack;
   logic       sda_in;

   modport source (output valid, command, write_data, send_ack, sda_in, input ready);
   modport sink   (input valid, command, write_data, send_ack, sda_in, output ready);
endinterface

interface i2cm_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_level;
   logic       sda_level;
   logic       pins_driven;
   logic       busy_res;
   logic       done_res;
   logic [7:0] read_byte;
   logic       ack_seen;
   logic       rejected;

   modport source (output valid, scl_level, sda_level, pins_driven, busy_res, done_res,
                   read_byte, ack_seen, rejected, input ready);
   modport sink   (input valid, scl_level, sda_level, pins_driven, busy_res, done_res,
                   read_byte, ack_seen, rejected, output ready);
endinterface

// File: rtl/i2c_master_byte_engine_core.sv
// Top level of the I2C master byte engine: front queue feeding the bus timing engine.
//
//   channel   dir  handshake      beat contents
//   req_chan  in   valid/ready    command, write_data, send_ack, sda_in (one bus tick)
//   rsp_chan  out  valid/ready    scl/sda levels, pins_driven, busy, done, read_byte,
//                                 ack_seen, rejected
//   csr_*     in   csr_we         csr_index selects unit_ticks or ack_wait_limit
//
// One tick is taken per cycle while the queue has room; each tick gives one response beat,
// registered first in the queue and then by the engine step into the response register.
// Throughput is one beat per cycle while the response is taken or its slot is free.
// Reset is synchronous and active high; it empties the queue and idles the bus.
// A stalled response stops the engine; the queue keeps taking ticks until full.
`timescale 1ns / 1ps

module i2c_master_byte_engine_core import i2cm_pkg::*; #(
   parameter int QUEUE_DEPTH = I2CM_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   i2cm_req_if.sink    req_chan,
   i2cm_rsp_if.source  rsp_chan,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   logic     q_valid;
   item_type q_item;
   logic     q_pop;

   i2cm_front #(
      .DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_pop    (q_pop)
   );

   i2cm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_chan  (rsp_chan)
   );

endmodule

// File: rtl/i2cm_front.sv
// Front end: accepts request beats, classifies the command, queues the tick.
`timescale 1ns / 1ps

module i2cm_front import i2cm_pkg::*; #(
   parameter int DEPTH = I2CM_QUEUE_DEPTH
) (
   input  logic     clock,
   input  logic     reset,
   i2cm_req_if.sink req_chan,
   output logic     q_valid,
   output item_type q_item,
   input  logic     q_pop
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

   item_type         queue_mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;
   item_type         new_item;

   function automatic cmd_type classify(input logic [2:0] code);
      cmd_type kind;
      case (code)
         CODE_NONE:  kind = KIND_NONE;
         CODE_TAKE:  kind = KIND_TAKE;
         CODE_START: kind = KIND_START;
         CODE_STOP:  kind = KIND_STOP;
         CODE_WRITE: kind = KIND_WRITE;
         CODE_READ:  kind = KIND_READ;
         default:    kind = KIND_UNKNOWN;
      endcase
      return kind;
   endfunction

   // Classify the incoming beat
   always_comb begin
      new_item.kind       = classify(req_chan.command);
      new_item.write_data = req_chan.write_data;
      new_item.send_ack   = req_chan.send_ack;
      new_item.sda_in     = req_chan.sda_in;
   end

   assign req_chan.ready = (count_ff != FULL_CNT);
   assign push           = req_chan.valid && req_chan.ready;
   assign q_valid        = (count_ff != '0);
   assign pop            = q_pop && q_valid;
   assign q_item         = queue_mem_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the classified beat
   always_ff @(posedge clock) begin
      if (push) begin
         queue_mem_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

// File: rtl/i2cm_back.sv
// Back end: bus timing engine, configuration registers and response stage.
`timescale 1ns / 1ps

module i2cm_back import i2cm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          q_valid,
   input  item_type      q_item,
   output logic          q_pop,
   input  logic          csr_we,
   input  logic          csr_index,
   input  logic [15:0]   csr_wdata,
   i2cm_rsp_if.source    rsp_chan
);

   typedef enum logic [14:0] {
      PH_IDLE   = 15'b000000000000001,
      PH_STA_A  = 15'b000000000000010,
      PH_STA_B  = 15'b000000000000100,
      PH_STA_C  = 15'b000000000001000,
      PH_STO_A  = 15'b000000000010000,
      PH_STO_B  = 15'b000000000100000,
      PH_STO_C  = 15'b000000001000000,
      PH_W_HI   = 15'b000000010000000,
      PH_W_LO   = 15'b000000100000000,
      PH_A_WAIT = 15'b000001000000000,
      PH_A_HOLD = 15'b000010000000000,
      PH_A_LO   = 15'b000100000000000,
      PH_R_HI   = 15'b001000000000000,
      PH_R_LO   = 15'b010000000000000,
      PH_R_TAIL = 15'b100000000000000
   } phase_type;

   // Units per phase: start and stop use long setup phases
   function automatic logic [7:0] phase_units(input phase_type ph);
      logic [7:0] units;
      case (ph)
         PH_STA_A, PH_STA_B, PH_STO_A, PH_STO_B: units = 8'd3;
         default:                                units = 8'd1;
      endcase
      return units;
   endfunction

   logic [15:0] unit_ticks_ff;
   logic [7:0]  ack_wait_ff;

   phase_type   phase_ff, phase_in;
   logic [3:0]  bit_count_ff, bit_count_in;
   logic [15:0] unit_count_ff, unit_count_in;
   logic [7:0]  wait_count_ff, wait_count_in;
   logic [7:0]  shift_ff, shift_in;
   logic        scl_ff, scl_in;
   logic        sda_ff, sda_in;
   logic        drive_ff, drive_in;
   logic        ack_mode_ff, ack_mode_in;
   logic        ack_ff, ack_in;
   logic [7:0]  read_ff, read_in;
   logic        ack_out_ff, ack_out_in;
   logic        done_ff, done_in;
   logic        rej_ff, rej_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic        pop;
   logic [15:0] t_eff;
   logic [7:0]  lim_eff;
   logic [15:0] uc_inc;
   logic [7:0]  wc_inc;
   logic [3:0]  bc_inc;
   logic [7:0]  shifted;
   logic        unit_done;
   logic        go;
   phase_type   go_phase;
   logic        go_scl;
   logic        go_sda;

   // Take a queued tick when the response slot is free or being drained
   assign pop   = q_valid && (!rsp_valid_ff || rsp_chan.ready);
   assign q_pop = pop;

   assign t_eff     = (unit_ticks_ff == '0) ? 16'd1 : unit_ticks_ff;
   assign lim_eff   = (ack_wait_ff == '0) ? 8'd1 : ack_wait_ff;
   assign uc_inc    = unit_count_ff + 16'd1;
   assign wc_inc    = wait_count_ff + 8'd1;
   assign bc_inc    = bit_count_ff + 4'd1;
   assign shifted   = {shift_ff[6:0], 1'b0};
   assign unit_done = (uc_inc >= t_eff);

   // Step the engine by one tick
   always_comb begin
      phase_in      = phase_ff;
      bit_count_in  = bit_count_ff;
      unit_count_in = unit_count_ff;
      wait_count_in = wait_count_ff;
      shift_in      = shift_ff;
      scl_in        = scl_ff;
      sda_in        = sda_ff;
      drive_in      = drive_ff;
      ack_mode_in   = ack_mode_ff;
      ack_in        = ack_ff;
      read_in       = read_ff;
      ack_out_in    = ack_out_ff;
      done_in       = 1'b0;
      rej_in        = 1'b0;
      go            = 1'b0;
      go_phase      = PH_IDLE;
      go_scl        = scl_ff;
      go_sda        = sda_ff;

      if (phase_ff == PH_IDLE) begin
         case (q_item.kind)
            KIND_TAKE: begin
               scl_in   = 1'b1;
               sda_in   = 1'b1;
               drive_in = 1'b1;
               done_in  = 1'b1;
            end
            KIND_START: begin
               drive_in = 1'b1;
               go = 1'b1; go_phase = PH_STA_A; go_scl = 1'b1; go_sda = 1'b1;
            end
            KIND_STOP: begin
               go = 1'b1; go_phase = PH_STO_A; go_sda = 1'b0;
            end
            KIND_WRITE: begin
               shift_in     = q_item.write_data;
               bit_count_in = '0;
               ack_mode_in  = 1'b0;
               go = 1'b1; go_phase = PH_W_HI; go_scl = 1'b1; go_sda = q_item.write_data[7];
            end
            KIND_READ: begin
               shift_in     = '0;
               bit_count_in = '0;
               ack_mode_in  = 1'b0;
               ack_out_in   = q_item.send_ack;
               go = 1'b1; go_phase = PH_R_HI; go_scl = 1'b1; go_sda = 1'b1;
            end
            default: begin
            end
         endcase
      end else begin
         rej_in = (q_item.kind != KIND_NONE);
         if (phase_ff == PH_A_WAIT) begin
            // Watch for the acknowledge on every tick, give up after the limit
            if (!q_item.sda_in) begin
               ack_in = 1'b1;
               go = 1'b1; go_phase = PH_A_HOLD; go_scl = 1'b1; go_sda = 1'b1;
            end else begin
               unit_count_in = unit_done ? '0 : uc_inc;
               wait_count_in = unit_done ? wc_inc : wait_count_ff;
               if (unit_done && wc_inc >= lim_eff) begin
                  ack_in = 1'b0;
                  go = 1'b1; go_phase = PH_A_HOLD; go_scl = 1'b1; go_sda = 1'b1;
               end
            end
         end else begin
            unit_count_in = unit_done ? '0 : uc_inc;
            wait_count_in = unit_done ? wc_inc : wait_count_ff;
            if (unit_done && wc_inc >= phase_units(phase_ff)) begin
               go = 1'b1;
               case (phase_ff)
                  PH_STA_A: begin go_phase = PH_STA_B; go_sda = 1'b0; end
                  PH_STA_B: begin go_phase = PH_STA_C; go_scl = 1'b0; end
                  PH_STO_A: begin go_phase = PH_STO_B; go_scl = 1'b1; end
                  PH_STO_B: begin go_phase = PH_STO_C; go_sda = 1'b1; end
                  PH_STO_C: begin
                     drive_in = 1'b0;
                     done_in  = 1'b1;
                  end
                  PH_W_HI: begin go_phase = PH_W_LO; go_scl = 1'b0; end
                  PH_W_LO: begin
                     if (ack_mode_ff) begin
                        go_phase = PH_R_TAIL;
                     end else begin
                        bit_count_in = bc_inc;
                        shift_in     = shifted;
                        if (bc_inc >= 4'd8) begin
                           go_phase = PH_A_WAIT; go_scl = 1'b1; go_sda = 1'b1;
                        end else begin
                           go_phase = PH_W_HI; go_scl = 1'b1; go_sda = shifted[7];
                        end
                     end
                  end
                  PH_A_HOLD: begin go_phase = PH_A_LO; go_scl = 1'b0; end
                  PH_R_HI: begin
                     shift_in = {shift_ff[6:0], q_item.sda_in};
                     go_phase = PH_R_LO; go_scl = 1'b0;
                  end
                  PH_R_LO: begin
                     bit_count_in = bc_inc;
                     if (bc_inc >= 4'd8) begin
                        read_in     = shift_ff;
                        ack_mode_in = 1'b1;
                        go_phase = PH_W_HI; go_scl = 1'b1; go_sda = !ack_out_ff;
                     end else begin
                        go_phase = PH_R_HI; go_scl = 1'b1; go_sda = 1'b1;
                     end
                  end
                  PH_R_TAIL: begin
                     ack_mode_in = 1'b0;
                     done_in     = 1'b1;
                  end
                  default: begin
                     // end of start, end of acknowledge low phase
                     done_in = 1'b1;
                  end
               endcase
            end
         end
      end

      // Enter the next phase: restart the counters and set the pins
      if (go) begin
         phase_in      = go_phase;
         unit_count_in = '0;
         wait_count_in = '0;
         scl_in        = go_scl;
         sda_in        = go_sda;
      end
   end

   assign rsp_valid_in = pop || (rsp_valid_ff && !rsp_chan.ready);

   // Hold engine state between taken ticks
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         bit_count_ff  <= '0;
         unit_count_ff <= '0;
         wait_count_ff <= '0;
         shift_ff      <= '0;
         scl_ff        <= 1'b1;
         sda_ff        <= 1'b1;
         drive_ff      <= 1'b0;
         ack_mode_ff   <= 1'b0;
         ack_ff        <= 1'b0;
         read_ff       <= '0;
         ack_out_ff    <= 1'b0;
         done_ff       <= 1'b0;
         rej_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            phase_ff      <= phase_in;
            bit_count_ff  <= bit_count_in;
            unit_count_ff <= unit_count_in;
            wait_count_ff <= wait_count_in;
            shift_ff      <= shift_in;
            scl_ff        <= scl_in;
            sda_ff        <= sda_in;
            drive_ff      <= drive_in;
            ack_mode_ff   <= ack_mode_in;
            ack_ff        <= ack_in;
            read_ff       <= read_in;
            ack_out_ff    <= ack_out_in;
            done_ff       <= done_in;
            rej_ff        <= rej_in;
         end
      end
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ticks_ff <= UNIT_TICKS_RESET;
         ack_wait_ff   <= ACK_WAIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_UNIT_TICKS: unit_ticks_ff <= csr_wdata;
            CSR_ACK_WAIT:   ack_wait_ff   <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   // Response beat reflects state after the last taken tick
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.scl_level   = scl_ff;
   assign rsp_chan.sda_level   = sda_ff;
   assign rsp_chan.pins_driven = drive_ff;
   assign rsp_chan.busy_res    = (phase_ff != PH_IDLE);
   assign rsp_chan.done_res    = done_ff;
   assign rsp_chan.read_byte   = read_ff;
   assign rsp_chan.ack_seen    = ack_ff;
   assign rsp_chan.rejected    = rej_ff;

   // A completed command leaves the engine idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && done_ff |-> phase_ff == PH_IDLE)
      else $error("done pulsed while a phase is still running");

   // A tick taken while idle is never rejected
   a_idle_no_reject: assert property (@(posedge clock) disable iff (reset)
      pop && phase_ff == PH_IDLE |=> !rej_ff)
      else $error("command rejected while idle");

   // Bit counter stops at a full byte
   a_bit_range: assert property (@(posedge clock) disable iff (reset)
      bit_count_ff <= 4'd8)
      else $error("bit counter ran past a byte");

   // Tick counter stays inside one delay unit
   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      unit_count_ff < t_eff)
      else $error("tick counter outside delay unit");

endmodule

// File: sim/i2c_master_byte_engine_core_tb.sv
// Testbench for the I2C master byte engine: bus ticks in, pin views checked against a predictor.
`timescale 1ns / 1ps

module i2c_master_byte_engine_core_tb;
   import i2cm_pkg::*;

   // Codes beyond the defined commands; an idle engine ignores them
   localparam logic [2:0] CODE_SPARE_A = 3'd6;
   localparam logic [2:0] CODE_SPARE_B = 3'd7;

   localparam longint RUN_LIMIT_NS = 64'd36_000_000;

   // Engine phases, in the order the bus sequences walk through them
   typedef enum logic [3:0] {
      SP_IDLE,
      SP_START_HI,
      SP_START_SDA_LO,
      SP_START_SCL_LO,
      SP_STOP_SDA_LO,
      SP_STOP_SCL_HI,
      SP_STOP_SDA_HI,
      SP_BIT_HI,
      SP_BIT_LO,
      SP_ACK_WAIT,
      SP_ACK_HOLD,
      SP_ACK_LO,
      SP_RBIT_HI,
      SP_RBIT_LO,
      SP_READ_TAIL
   } bus_phase_type;

   typedef struct packed {
      logic       scl;
      logic       sda;
      logic       driven;
      logic       busy;
      logic       done;
      logic [7:0] rbyte;
      logic       acked;
      logic       rej;
   } bus_view_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_we;
   logic        csr_index;
   logic [15:0] csr_wdata;

   i2cm_req_if req_chan ();
   i2cm_rsp_if rsp_chan ();

   i2c_master_byte_engine_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Predictor state, mirrors the engine after each accepted tick
   logic [15:0]   cfg_unit_ticks = UNIT_TICKS_RESET;
   logic [7:0]    cfg_ack_limit  = ACK_WAIT_RESET;
   bus_phase_type eng_phase      = SP_IDLE;
   logic [3:0]    eng_bitpos     = '0;
   logic [15:0]   eng_ticks      = '0;
   logic [7:0]    eng_units      = '0;
   logic [7:0]    eng_shift      = '0;
   logic          eng_scl        = 1'b1;
   logic          eng_sda        = 1'b1;
   logic          eng_drive      = 1'b0;
   logic          eng_ack_bit    = 1'b0;
   logic          eng_acked      = 1'b0;
   logic [7:0]    eng_rbyte      = '0;
   logic          eng_answer     = 1'b0;

   bus_view_type  due_views[$];

   int unsigned err_count   = 0;
   int unsigned beat_count  = 0;
   int unsigned tick_count  = 0;
   int unsigned cmd_count   = 0;
   int unsigned csr_count   = 0;
   int unsigned rej_count   = 0;
   int unsigned ack_count   = 0;
   int unsigned gap_pct     = 0;
   int unsigned stall_pct   = 0;
   int unsigned stall_left  = 0;

   // ---------------------------------------------------------------- predictor

   function automatic void enter_phase(bus_phase_type p, logic scl, logic sda);
      eng_phase = p;
      eng_ticks = '0;
      eng_units = '0;
      eng_scl   = scl;
      eng_sda   = sda;
   endfunction

   // Count one tick; true when a delay unit completes
   function automatic logic tick_unit();
      logic [15:0] len;
      len = (cfg_unit_ticks == 16'd0) ? 16'd1 : cfg_unit_ticks;
      eng_ticks = eng_ticks + 16'd1;
      if (eng_ticks >= len) begin
         eng_ticks = '0;
         eng_units = eng_units + 8'd1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic logic [7:0] phase_length(bus_phase_type p);
      case (p)
         SP_START_HI, SP_START_SDA_LO, SP_STOP_SDA_LO, SP_STOP_SCL_HI: return 8'd3;
         default: return 8'd1;
      endcase
   endfunction

   // Advance a busy engine one tick; true when the command finishes
   function automatic logic advance_phase(logic sin);
      logic [7:0] lim;
      logic       unit_done;
      lim = (cfg_ack_limit == 8'd0) ? 8'd1 : cfg_ack_limit;
      if (eng_phase == SP_ACK_WAIT) begin
         if (!sin) begin
            eng_acked = 1'b1;
            ack_count++;
            enter_phase(SP_ACK_HOLD, 1'b1, 1'b1);
         end else begin
            unit_done = tick_unit();
            if (unit_done && eng_units >= lim) begin
               eng_acked = 1'b0;
               enter_phase(SP_ACK_HOLD, 1'b1, 1'b1);
            end
         end
         return 1'b0;
      end
      unit_done = tick_unit();
      if (!unit_done || eng_units < phase_length(eng_phase))
         return 1'b0;
      case (eng_phase)
         SP_START_HI:     enter_phase(SP_START_SDA_LO, eng_scl, 1'b0);
         SP_START_SDA_LO: enter_phase(SP_START_SCL_LO, 1'b0, eng_sda);
         SP_STOP_SDA_LO:  enter_phase(SP_STOP_SCL_HI, 1'b1, eng_sda);
         SP_STOP_SCL_HI:  enter_phase(SP_STOP_SDA_HI, eng_scl, 1'b1);
         SP_STOP_SDA_HI: begin
            eng_drive = 1'b0;
            enter_phase(SP_IDLE, eng_scl, eng_sda);
            return 1'b1;
         end
         SP_BIT_HI:       enter_phase(SP_BIT_LO, 1'b0, eng_sda);
         SP_BIT_LO: begin
            // the answer bit of a read reuses the write bit timing
            if (eng_ack_bit) begin
               enter_phase(SP_READ_TAIL, eng_scl, eng_sda);
            end else begin
               eng_bitpos = eng_bitpos + 4'd1;
               eng_shift  = {eng_shift[6:0], 1'b0};
               if (eng_bitpos >= 4'd8)
                  enter_phase(SP_ACK_WAIT, 1'b1, 1'b1);
               else
                  enter_phase(SP_BIT_HI, 1'b1, eng_shift[7]);
            end
         end
         SP_ACK_HOLD:     enter_phase(SP_ACK_LO, 1'b0, eng_sda);
         SP_RBIT_HI: begin
            eng_shift = {eng_shift[6:0], sin};
            enter_phase(SP_RBIT_LO, 1'b0, eng_sda);
         end
         SP_RBIT_LO: begin
            eng_bitpos = eng_bitpos + 4'd1;
            if (eng_bitpos >= 4'd8) begin
               eng_rbyte   = eng_shift;
               eng_ack_bit = 1'b1;
               enter_phase(SP_BIT_HI, 1'b1, !eng_answer);
            end else begin
               enter_phase(SP_RBIT_HI, 1'b1, 1'b1);
            end
         end
         SP_READ_TAIL: begin
            eng_ack_bit = 1'b0;
            enter_phase(SP_IDLE, eng_scl, eng_sda);
            return 1'b1;
         end
         default: begin
            enter_phase(SP_IDLE, eng_scl, eng_sda);
            return 1'b1;
         end
      endcase
      return 1'b0;
   endfunction

   // Apply one bus tick and return the pin view the engine should show
   function automatic bus_view_type next_bus_view(logic [2:0] cmd, logic [7:0] wd, logic sack,
                                                  logic sin);
      bus_view_type v;
      logic         rej;
      logic         done;
      rej  = 1'b0;
      done = 1'b0;
      if (eng_phase == SP_IDLE) begin
         case (cmd)
            CODE_TAKE: begin
               eng_scl   = 1'b1;
               eng_sda   = 1'b1;
               eng_drive = 1'b1;
               done      = 1'b1;
            end
            CODE_START: begin
               eng_drive = 1'b1;
               enter_phase(SP_START_HI, 1'b1, 1'b1);
            end
            CODE_STOP: enter_phase(SP_STOP_SDA_LO, eng_scl, 1'b0);
            CODE_WRITE: begin
               eng_shift   = wd;
               eng_bitpos  = '0;
               eng_ack_bit = 1'b0;
               enter_phase(SP_BIT_HI, 1'b1, wd[7]);
            end
            CODE_READ: begin
               eng_shift   = '0;
               eng_bitpos  = '0;
               eng_ack_bit = 1'b0;
               eng_answer  = sack;
               enter_phase(SP_RBIT_HI, 1'b1, 1'b1);
            end
            default: ;
         endcase
      end else begin
         rej  = (cmd != CODE_NONE);
         done = advance_phase(sin);
      end
      if (rej)
         rej_count++;
      v.scl    = eng_scl;
      v.sda    = eng_sda;
      v.driven = eng_drive;
      v.busy   = (eng_phase != SP_IDLE);
      v.done   = done;
      v.rbyte  = eng_rbyte;
      v.acked  = eng_acked;
      v.rej    = rej;
      return v;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(string msg);
      if (err_count < 100)
         $display("[%0t] MISMATCH %s", $realtime, msg);
      err_count++;
   endtask

   task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
         report_mismatch($sformatf("beat %0d %s: got %0h, want %0h",
                                   beat_count, name, got, want));
   endtask

   task automatic check_view();
      bus_view_type want;
      if (due_views.size() == 0) begin
         report_mismatch($sformatf("beat %0d arrived with nothing outstanding", beat_count));
      end else begin
         want = due_views.pop_front();
         check_field("scl_level", 8'(rsp_chan.scl_level), 8'(want.scl));
         check_field("sda_level", 8'(rsp_chan.sda_level), 8'(want.sda));
         check_field("pins_driven", 8'(rsp_chan.pins_driven), 8'(want.driven));
         check_field("busy_res", 8'(rsp_chan.busy_res), 8'(want.busy));
         check_field("done_res", 8'(rsp_chan.done_res), 8'(want.done));
         check_field("read_byte", rsp_chan.read_byte, want.rbyte);
         check_field("ack_seen", 8'(rsp_chan.ack_seen), 8'(want.acked));
         check_field("rejected", 8'(rsp_chan.rejected), 8'(want.rej));
      end
      beat_count++;
   endtask

   // Check every response beat against the oldest outstanding view
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)
         check_view();
   end

   // Drop response ready in random bursts
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left     <= stall_left - 1;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
         rsp_chan.ready <= 1'b0;
         stall_left     <= $urandom_range(0, 16);
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------- stimulus

   // Send one bus tick, with an optional idle burst ahead of it
   task automatic send_tick(logic [2:0] cmd, logic [7:0] wd, logic sack, logic sin);
      int unsigned gap;
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         gap = $urandom_range(1, 17);
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.command    <= cmd;
      req_chan.write_data <= wd;
      req_chan.send_ack   <= sack;
      req_chan.sda_in     <= sin;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
      due_views.push_back(next_bus_view(cmd, wd, sack, sin));
      tick_count++;
   endtask

   // Hold off until every outstanding view has been checked
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      while (due_views.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [15:0] value);
      drain_results();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_UNIT_TICKS)
         cfg_unit_ticks = value;
      else
         cfg_ack_limit = value[7:0];
      csr_count++;
   endtask

   // Issue one command and tick the bus until the engine is idle again.
   // The slave acks ack_after ticks into the wait (negative: never) and
   // drives slave_byte on read bits; other ticks carry random SDA.
   task automatic run_command(logic [2:0] cmd, logic [7:0] wd, logic sack,
                              logic [7:0] slave_byte, int ack_after, int unsigned noise_pct);
      logic [2:0] busy_cmd;
      logic       sin;
      int         waited;
      waited = 0;
      cmd_count++;
      send_tick(cmd, wd, sack, 1'($urandom_range(0, 1)));
      while (eng_phase != SP_IDLE) begin
         busy_cmd = CODE_NONE;
         if ($urandom_range(0, 99) < noise_pct)
            busy_cmd = 3'($urandom_range(1, 7));
         if (eng_phase == SP_ACK_WAIT) begin
            sin = !(ack_after >= 0 && waited >= ack_after);
            waited++;
         end else if (eng_phase == SP_RBIT_HI) begin
            sin = slave_byte[3'd7 - eng_bitpos[2:0]];
         end else begin
            sin = 1'($urandom_range(0, 1));
         end
         send_tick(busy_cmd, 8'($urandom), 1'($urandom_range(0, 1)), sin);
      end
   endtask

   // Idle ticks, spare codes, bus take and START at reset timing
   task automatic test_idle_and_spare_codes();
      gap_pct   = 8;
      stall_pct <= 8;
      run_command(CODE_NONE, 8'h00, 1'b0, 8'h00, 0, 0);
      run_command(CODE_NONE, 8'hFF, 1'b1, 8'h00, 0, 0);
      run_command(CODE_SPARE_A, 8'h5A, 1'b0, 8'h00, 0, 0);
      run_command(CODE_SPARE_B, 8'hA5, 1'b1, 8'h00, 0, 0);
      run_command(CODE_TAKE, 8'h00, 1'b0, 8'h00, 0, 0);
      run_command(CODE_START, 8'h00, 1'b0, 8'h00, 0, 15);
   endtask

   // Write and read with the bus released after STOP
   task automatic test_bus_not_taken();
      write_reg(CSR_UNIT_TICKS, 16'd1);
      run_command(CODE_STOP, 8'h00, 1'b0, 8'h00, 0, 5);
      run_command(CODE_WRITE, 8'h00, 1'b0, 8'h00, 0, 5);
      run_command(CODE_READ, 8'h00, 1'b1, 8'hFF, 0, 5);
      run_command(CODE_STOP, 8'h00, 1'b0, 8'h00, 0, 5);
   endtask

   // Byte extremes, acked and timed-out writes, ACK and NACK reads
   task automatic test_byte_extremes();
      run_command(CODE_TAKE, 8'h00, 1'b0, 8'h00, 0, 0);
      run_command(CODE_START, 8'h00, 1'b0, 8'h00, 0, 10);
      run_command(CODE_WRITE, 8'hFF, 1'b0, 8'h00, 3, 10);
      run_command(CODE_WRITE, 8'h00, 1'b1, 8'h00, -1, 10);
      run_command(CODE_WRITE, 8'h80, 1'b0, 8'h00, 0, 0);
      run_command(CODE_READ, 8'h00, 1'b0, 8'h00, 0, 10);
      run_command(CODE_READ, 8'h00, 1'b1, 8'hFF, 0, 10);
      run_command(CODE_START, 8'h00, 1'b0, 8'h00, 0, 0);
      run_command(CODE_STOP, 8'h00, 1'b0, 8'h00, 0, 10);
   endtask

   // Zero unit length and zero wait limit both act as one
   task automatic test_zero_settings();
      write_reg(CSR_UNIT_TICKS, 16'd0);
      write_reg(CSR_ACK_WAIT, 16'd0);
      run_command(CODE_TAKE, 8'h00, 1'b0, 8'h00, 0, 0);
      run_command(CODE_START, 8'h00, 1'b0, 8'h00, 0, 5);
      run_command(CODE_WRITE, 8'h3C, 1'b0, 8'h00, -1, 5);
      run_command(CODE_READ, 8'h00, 1'b0, 8'hC3, 0, 5);
      run_command(CODE_STOP, 8'h00, 1'b0, 8'h00, 0, 5);
   endtask

   // Longest acknowledge window, run out to the timeout
   task automatic test_long_ack_wait();
      write_reg(CSR_UNIT_TICKS, 16'd1);
      write_reg(CSR_ACK_WAIT, 16'd255);
      run_command(CODE_WRITE, 8'h5A, 1'b1, 8'h00, -1, 2);
   endtask

   // Random ack delay: mostly inside the window, sometimes never
   function automatic int pick_ack_after();
      int unsigned span;
      span = (cfg_unit_ticks == 0 ? 1 : cfg_unit_ticks) *
             (cfg_ack_limit == 0 ? 1 : cfg_ack_limit);
      if ($urandom_range(0, 4) == 0)
         return -1;
      return $urandom_range(0, span + 2);
   endfunction

   // One transaction: optional take, START, address, data bytes, usually STOP
   task automatic run_transfer();
      int unsigned n;
      if ($urandom_range(0, 1) == 0)
         run_command(CODE_TAKE, 8'($urandom), 1'($urandom_range(0, 1)), 8'h00, 0, 3);
      run_command(CODE_START, 8'($urandom), 1'($urandom_range(0, 1)), 8'h00, 0, 3);
      run_command(CODE_WRITE, 8'($urandom), 1'($urandom_range(0, 1)), 8'h00,
                  pick_ack_after(), 3);
      n = $urandom_range(0, 3);
      repeat (n) begin
         if ($urandom_range(0, 1) == 0)
            run_command(CODE_READ, 8'($urandom), 1'($urandom_range(0, 1)), 8'($urandom),
                        0, 3);
         else
            run_command(CODE_WRITE, 8'($urandom), 1'($urandom_range(0, 1)), 8'h00,
                        pick_ack_after(), 3);
      end
      // leave some transfers open so the next START repeats
      if ($urandom_range(0, 9) != 0)
         run_command(CODE_STOP, 8'($urandom), 1'($urandom_range(0, 1)), 8'h00, 0, 3);
   endtask

   task automatic test_random_transfers();
      int unsigned phase_end;
      repeat (2) begin
         write_reg(CSR_UNIT_TICKS, 16'($urandom_range(1, 2)));
         write_reg(CSR_ACK_WAIT, 16'($urandom_range(1, 6)));
         case ($urandom_range(0, 2))
            0: gap_pct = 0;
            1: gap_pct = 5;
            default: gap_pct = 20;
         endcase
         case ($urandom_range(0, 2))
            0: stall_pct <= 0;
            1: stall_pct <= 5;
            default: stall_pct <= 20;
         endcase
         phase_end = tick_count + 40;
         while (tick_count < phase_end) begin
            if ($urandom_range(0, 9) == 0)
               run_command(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom_range(0, 1)),
                           8'($urandom), pick_ack_after(), 10);
            else
               run_transfer();
         end
      end
   endtask

   // Close with a full transfer run back to back with no idling
   task automatic test_back_to_back_tail();
      gap_pct   = 0;
      stall_pct <= 0;
      write_reg(CSR_UNIT_TICKS, 16'd1);
      write_reg(CSR_ACK_WAIT, 16'd4);
      run_command(CODE_TAKE, 8'h00, 1'b0, 8'h00, 0, 0);
      run_command(CODE_START, 8'h00, 1'b0, 8'h00, 0, 1);
      run_command(CODE_WRITE, 8'hC5, 1'b0, 8'h00, 1, 1);
      run_command(CODE_READ, 8'h00, 1'b1, 8'h3A, 0, 1);
      run_command(CODE_STOP, 8'h00, 1'b0, 8'h00, 0, 1);
   endtask

   initial begin
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_index           = CSR_UNIT_TICKS;
      csr_wdata           = '0;
      req_chan.valid      = 1'b0;
      req_chan.command    = CODE_NONE;
      req_chan.write_data = '0;
      req_chan.send_ack   = 1'b0;
      req_chan.sda_in     = 1'b1;
      rsp_chan.ready      = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_idle_and_spare_codes();
      test_bus_not_taken();
      test_byte_extremes();
      test_zero_settings();
      test_long_ack_wait();
      test_random_transfers();
      test_back_to_back_tail();

      drain_results();
      repeat (8) @(posedge clock);

      $display("Covered %0d bus ticks, %0d commands and %0d register writes.",
               tick_count, cmd_count, csr_count);
      $display("Checked %0d response beats; %0d busy commands refused, %0d bytes acked.",
               beat_count, rej_count, ack_count);
      if (err_count == 0 && due_views.size() == 0)
         $display("i2c_master_byte_engine_core test passed");
      else
         $display("i2c_master_byte_engine_core test failed");
      $finish;
   end

   // Stop a hung run
   initial begin
      #(RUN_LIMIT_NS);
      $display("Timed out with %0d beats outstanding.", due_views.size());
      $display("i2c_master_byte_engine_core test failed");
      $finish;
   end

endmodule
